// ----- hw/rtl/bswr_pkg.sv -----
package bswr_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 16;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = $clog2(DEPTH);

	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_PEEK   = 2'd2;
	localparam logic [1:0] ACT_REMOVE = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  count;
	} res_t;

	typedef struct packed {
		logic valid;
		logic wr;
		logic shift;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/bswr_cell.sv -----
module bswr_cell
	import bswr_pkg::*;
(
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [DATA_W-1:0] up_data,
	input  logic [DATA_W-1:0] key,
	input  logic              above_in,
	output logic [DATA_W-1:0] data_q,
	output logic              above_out
);

	logic match;

	assign match     = ctl.valid && (data_q == key);
	assign above_out = above_in || match;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			data_q <= wr_data;
		end else if (ctl.shift) begin
			data_q <= up_data;
		end
	end

endmodule

// ----- hw/rtl/bounded_stack_with_remove.sv -----
// Channel   Ports                  Handshake
// command   cmd (cmd_t)            accepted when start is high and busy is low
// result    result (res_t)         valid for the one cycle that done is high
//
// The result appears in the cycle after the command is accepted, and a new command
// may be accepted in every cycle.
// Each cell compares its entry with the key and a match chain from the top
// cell downward selects which cells shift for a remove.
// Reset clears the entry count and the result strobe; entries are not cleared.
// The receiver cannot stall, so busy is never raised.
module bounded_stack_with_remove
	import bswr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	res_t              result_q;

	cell_ctl_t         ctl       [DEPTH];
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic              chain     [DEPTH+1];

	logic              take;
	logic              is_push;
	logic              is_pop;
	logic              is_remove;
	logic              full;
	logic              empty;
	logic              found;
	logic [IDX_W-1:0]  top_idx;
	logic [CNT_W-1:0]  top_cnt;
	res_t              res_d;
	logic [CNT_W-1:0]  count_d;

	assign busy      = 1'b0;
	assign take      = start && !busy;
	assign is_push   = cmd.action == ACT_PUSH;
	assign is_pop    = cmd.action == ACT_POP;
	assign is_remove = cmd.action == ACT_REMOVE;
	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign top_cnt   = count_q - CNT_W'(1);
	assign top_idx   = top_cnt[IDX_W-1:0];
	assign chain[DEPTH] = 1'b0;
	assign found     = chain[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ctl[i] = cell_ctl_t'{
			valid: CNT_W'(i) < count_q,
			wr:    take && is_push && !full && (count_q == CNT_W'(i)),
			shift: take && is_remove && found && !chain[i+1]
		};

		bswr_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[i]),
			.wr_data  (cmd.value),
			.up_data  ((i == DEPTH - 1) ? '0 : cell_data[(i + 1) % DEPTH]),
			.key      (cmd.value),
			.above_in (chain[i+1]),
			.data_q   (cell_data[i]),
			.above_out(chain[i])
		);
	end

	always_comb begin
		res_d   = '0;
		count_d = count_q;
		unique case (cmd.action) inside
			ACT_PUSH: begin
				if (!full) begin
					res_d.ok = 1'b1;
					count_d  = count_q + CNT_W'(1);
				end
			end
			ACT_POP, ACT_PEEK: begin
				if (!empty) begin
					res_d.ok   = 1'b1;
					res_d.data = cell_data[top_idx];
					if (is_pop) begin
						count_d = top_cnt;
					end
				end
			end
			ACT_REMOVE: begin
				if (found) begin
					res_d.ok = 1'b1;
					count_d  = top_cnt;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
		res_d.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
